[design/lobm_pkg.sv]
package lobm_pkg;

	localparam int unsigned PW = 31;  // price, quantity and id width
	localparam int unsigned TW = 16;  // trader index width
	localparam int unsigned AW = 32;  // arrival stamp width

	localparam logic [1:0] KIND_TRADE  = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	// result word to launch from the controller
	localparam logic [2:0] EM_NONE      = 3'd0;
	localparam logic [2:0] EM_PEND      = 3'd1;
	localparam logic [2:0] EM_PEND_LAST = 3'd2;
	localparam logic [2:0] EM_DONE      = 3'd3;
	localparam logic [2:0] EM_REJECT    = 3'd4;
	localparam logic [2:0] EM_CANCEL    = 3'd5;

	typedef struct packed {
		logic       load;
		logic       match_init;
		logic       fill;
		logic       cancel;
		logic       rest_try;
		logic [2:0] emit;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic is_cancel;
		logic found;
		logic best_ok;
		logic cont;
		logic n_zero;
		logic n_full;
		logic reject;
	} stat_t;

endpackage

[design/limit_order_book_matcher_core.sv]
// Price-time priority order book with SLOTS_PER_SIDE bid slots and as many ask
// slots. Raise start with a request while busy is low; the request is taken at
// that edge and busy stays high until its last result word has been launched.
// Result words appear for exactly one cycle each, marked by result_strobe, and
// cannot be held off; the final word of every request has last_of_run set.
// Every request first walks all 2*N slots of the slot memory, one per cycle,
// to find its id and a free slot; each fill then walks the N opposite-side
// slots again for the best price and earliest arrival (plus one more walk
// when the book stops crossing), and the run closes by resting any remainder
// and reporting. One read port of the slot memory sets the pace.
module limit_order_book_matcher_core #(
	parameter int unsigned SLOTS_PER_SIDE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [30:0] order_ref,
	input  logic        order_side,
	input  logic        is_market,
	input  logic [30:0] limit_price,
	input  logic [30:0] order_qty,
	input  logic [15:0] trader_ref,
	output logic        result_strobe,
	output logic [1:0]  result_kind,
	output logic        last_of_run,
	output logic [30:0] taker_ref,
	output logic [30:0] maker_ref,
	output logic [15:0] taker_trader,
	output logic [15:0] maker_trader,
	output logic [30:0] trade_price,
	output logic [30:0] trade_qty,
	output logic        taker_side,
	output logic [30:0] rested_qty
);

	lobm_pkg::cmd_t  cmd;
	lobm_pkg::stat_t stat;

	// sequence the slot walks and the result words
	lobm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// slot memory, scan compare, fill arithmetic and result register
	lobm_dp #(
		.SLOTS_PER_SIDE (SLOTS_PER_SIDE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req_type),
		.order_ref     (order_ref),
		.order_side    (order_side),
		.is_market     (is_market),
		.limit_price   (limit_price),
		.order_qty     (order_qty),
		.trader_ref    (trader_ref),
		.result_strobe (result_strobe),
		.result_kind   (result_kind),
		.last_of_run   (last_of_run),
		.taker_ref     (taker_ref),
		.maker_ref     (maker_ref),
		.taker_trader  (taker_trader),
		.maker_trader  (maker_trader),
		.trade_price   (trade_price),
		.trade_qty     (trade_qty),
		.taker_side    (taker_side),
		.rested_qty    (rested_qty)
	);

	// the closing word of a run lands as the block goes idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_of_run |-> !busy)
		else $error("last word while still busy");

	// a word that is not last only comes mid-run
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_of_run |-> busy)
		else $error("non-final word while idle");

	// a fresh request gives no word in its first cycle
	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !result_strobe)
		else $error("word right after accept");

	// a trade always moves some quantity
	a_trade_qty: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (result_kind == lobm_pkg::KIND_TRADE) |-> trade_qty != '0)
		else $error("empty trade");

endmodule

[design/lobm_ctrl.sv]
module lobm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  lobm_pkg::stat_t stat,
	output lobm_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ID    = 3'd1;
	localparam logic [2:0] S_MATCH = 3'd2;
	localparam logic [2:0] S_FILL  = 3'd3;
	localparam logic [2:0] S_NEXT  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;
	localparam logic [2:0] S_REJ   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.emit  = lobm_pkg::EM_NONE;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_ID;
				end
			end
			S_ID: begin
				if (stat.scan_done) begin
					if (stat.is_cancel) begin
						cmd.cancel = stat.found;
						cmd.emit   = stat.found ? lobm_pkg::EM_CANCEL : lobm_pkg::EM_REJECT;
						state_nxt  = S_IDLE;
					end else if (stat.found) begin
						cmd.emit  = lobm_pkg::EM_REJECT;
						state_nxt = S_IDLE;
					end else begin
						state_nxt = S_NEXT;
					end
				end
			end
			S_MATCH: begin
				if (stat.scan_done) begin
					state_nxt = stat.best_ok ? S_FILL : S_FIN;
				end
			end
			S_FILL: begin
				cmd.fill  = 1'b1;
				state_nxt = S_NEXT;
			end
			S_NEXT: begin
				if (stat.cont) begin
					cmd.match_init = 1'b1;
					state_nxt      = S_MATCH;
				end else begin
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				cmd.rest_try = 1'b1;
				state_nxt    = S_OUT;
			end
			S_OUT: begin
				priority if (stat.reject && !stat.n_full) begin
					if (stat.n_zero) begin
						cmd.emit  = lobm_pkg::EM_REJECT;
						state_nxt = S_IDLE;
					end else begin
						cmd.emit  = lobm_pkg::EM_PEND;
						state_nxt = S_REJ;
					end
				end else if (stat.n_zero) begin
					cmd.emit  = lobm_pkg::EM_DONE;
					state_nxt = S_IDLE;
				end else begin
					cmd.emit  = lobm_pkg::EM_PEND_LAST;
					state_nxt = S_IDLE;
				end
			end
			S_REJ: begin
				cmd.emit  = lobm_pkg::EM_REJECT;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

[design/lobm_dp.sv]
module lobm_dp #(
	parameter int unsigned SLOTS_PER_SIDE = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lobm_pkg::cmd_t           cmd,
	output lobm_pkg::stat_t          stat,
	input  logic                     req_type,
	input  logic [lobm_pkg::PW-1:0]  order_ref,
	input  logic                     order_side,
	input  logic                     is_market,
	input  logic [lobm_pkg::PW-1:0]  limit_price,
	input  logic [lobm_pkg::PW-1:0]  order_qty,
	input  logic [lobm_pkg::TW-1:0]  trader_ref,
	output logic                     result_strobe,
	output logic [1:0]               result_kind,
	output logic                     last_of_run,
	output logic [lobm_pkg::PW-1:0]  taker_ref,
	output logic [lobm_pkg::PW-1:0]  maker_ref,
	output logic [lobm_pkg::TW-1:0]  taker_trader,
	output logic [lobm_pkg::TW-1:0]  maker_trader,
	output logic [lobm_pkg::PW-1:0]  trade_price,
	output logic [lobm_pkg::PW-1:0]  trade_qty,
	output logic                     taker_side,
	output logic [lobm_pkg::PW-1:0]  rested_qty
);

	localparam int unsigned NS = 2 * SLOTS_PER_SIDE;
	localparam int unsigned IW = $clog2(NS);
	localparam int unsigned CW = $clog2(NS + 1);
	localparam int unsigned NW = $clog2(SLOTS_PER_SIDE + 1);
	localparam int unsigned PW = lobm_pkg::PW;
	localparam int unsigned TW = lobm_pkg::TW;
	localparam int unsigned AW = lobm_pkg::AW;

	// order slot memory
	logic [PW-1:0] mem_price [NS];
	logic [PW-1:0] mem_qty   [NS];
	logic [PW-1:0] mem_id    [NS];
	logic [TW-1:0] mem_tr    [NS];
	logic [AW-1:0] mem_arr   [NS];
	logic [NS-1:0] valid_q;

	// request
	logic          type_q, side_q, mkt_q;
	logic [PW-1:0] ref_q, lim_q, rem_q, rested_q;
	logic [TW-1:0] tr_q;
	logic [AW-1:0] cnt_q;

	// scan control
	logic          mode_q;
	logic [IW-1:0] addr_q;
	logic [CW-1:0] left_q;
	logic          v_s1, sv_s1;
	logic [IW-1:0] idx_s1;
	logic [PW-1:0] rp_s1, rq_s1, rid_s1;
	logic [TW-1:0] rtr_s1;
	logic [AW-1:0] ra_s1;

	// id scan results
	logic          fnd_q, free_ok_q, rej_q;
	logic [IW-1:0] fidx_q, free_idx_q;
	logic [TW-1:0] ftr_q;

	// best resting order
	logic          bok_q;
	logic [IW-1:0] bidx_q;
	logic [PW-1:0] bp_q, bq_q, bid_q;
	logic [TW-1:0] btr_q;
	logic [AW-1:0] bage_q;

	// held trade, waiting to learn whether it ends the run
	logic [NW-1:0] n_q;
	logic [PW-1:0] pm_q, pp_q, pq_q;
	logic [TW-1:0] pt_q;

	logic          ask_s1, near_s1, hit_s1, cross_s1, better_s1;
	logic [AW-1:0] age_s1;
	logic [PW-1:0] fill_w, left_qty_w;
	logic          rest_do;
	logic [IW-1:0] waddr;

	assign ask_s1  = (idx_s1 >= IW'(SLOTS_PER_SIDE));
	assign near_s1 = (ask_s1 == side_q);
	assign hit_s1  = sv_s1 && (rid_s1 == ref_q);
	assign age_s1  = cnt_q - ra_s1;
	assign cross_s1 = mkt_q || (side_q ? (rp_s1 >= lim_q) : (rp_s1 <= lim_q));

	always_comb begin
		if (!bok_q) begin
			better_s1 = 1'b1;
		end else if (rp_s1 != bp_q) begin
			better_s1 = side_q ? (rp_s1 > bp_q) : (rp_s1 < bp_q);
		end else begin
			better_s1 = (age_s1 > bage_q);
		end
	end

	assign fill_w     = (rem_q < bq_q) ? rem_q : bq_q;
	assign left_qty_w = bq_q - fill_w;
	assign rest_do    = cmd.rest_try && (rem_q != '0) && !mkt_q && free_ok_q;
	assign waddr      = rest_do ? free_idx_q : bidx_q;

	always_ff @(posedge clk) begin
		if (cmd.fill || rest_do) begin
			mem_qty[waddr] <= rest_do ? rem_q : left_qty_w;
		end
		if (rest_do) begin
			mem_price[waddr] <= lim_q;
			mem_id[waddr]    <= ref_q;
			mem_tr[waddr]    <= tr_q;
			mem_arr[waddr]   <= cnt_q;
		end
		rp_s1  <= mem_price[addr_q];
		rq_s1  <= mem_qty[addr_q];
		rid_s1 <= mem_id[addr_q];
		rtr_s1 <= mem_tr[addr_q];
		ra_s1  <= mem_arr[addr_q];
		idx_s1 <= addr_q;
		sv_s1  <= valid_q[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.cancel) begin
				valid_q[fidx_q] <= 1'b0;
			end
			if (cmd.fill && (left_qty_w == '0)) begin
				valid_q[bidx_q] <= 1'b0;
			end
			if (rest_do) begin
				valid_q[free_idx_q] <= 1'b1;
			end
		end
	end

	// scan sequencing and request state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			v_s1      <= 1'b0;
			addr_q    <= '0;
			mode_q    <= 1'b0;
			cnt_q     <= '0;
			fnd_q     <= 1'b0;
			free_ok_q <= 1'b0;
			rej_q     <= 1'b0;
			bok_q     <= 1'b0;
			n_q       <= '0;
		end else begin
			v_s1 <= (left_q != '0);
			if (left_q != '0) begin
				addr_q <= addr_q + 1'b1;
				left_q <= left_q - 1'b1;
			end
			if (cmd.load) begin
				addr_q    <= '0;
				left_q    <= CW'(NS);
				mode_q    <= 1'b0;
				fnd_q     <= 1'b0;
				free_ok_q <= 1'b0;
				rej_q     <= 1'b0;
				bok_q     <= 1'b0;
				n_q       <= '0;
			end
			if (cmd.match_init) begin
				addr_q <= side_q ? '0 : IW'(SLOTS_PER_SIDE);
				left_q <= CW'(SLOTS_PER_SIDE);
				mode_q <= 1'b1;
				bok_q  <= 1'b0;
			end
			if (v_s1 && !mode_q) begin
				if (hit_s1 && !fnd_q) begin
					fnd_q <= 1'b1;
				end
				if (!sv_s1 && near_s1 && !free_ok_q) begin
					free_ok_q <= 1'b1;
				end
			end
			if (v_s1 && mode_q && sv_s1 && cross_s1 && better_s1) begin
				bok_q <= 1'b1;
			end
			if (cmd.fill) begin
				n_q <= n_q + 1'b1;
			end
			if (cmd.rest_try && (rem_q != '0) && !mkt_q) begin
				if (free_ok_q) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					rej_q <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q   <= req_type;
			ref_q    <= order_ref;
			side_q   <= order_side;
			mkt_q    <= is_market;
			lim_q    <= limit_price;
			rem_q    <= order_qty;
			tr_q     <= trader_ref;
			rested_q <= '0;
		end
		if (v_s1 && !mode_q) begin
			if (hit_s1 && !fnd_q) begin
				fidx_q <= idx_s1;
				ftr_q  <= rtr_s1;
			end
			if (!sv_s1 && near_s1 && !free_ok_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (v_s1 && mode_q && sv_s1 && cross_s1 && better_s1) begin
			bidx_q <= idx_s1;
			bp_q   <= rp_s1;
			bq_q   <= rq_s1;
			bid_q  <= rid_s1;
			btr_q  <= rtr_s1;
			bage_q <= age_s1;
		end
		if (cmd.fill) begin
			rem_q <= rem_q - fill_w;
			pm_q  <= bid_q;
			pt_q  <= btr_q;
			pp_q  <= bp_q;
			pq_q  <= fill_w;
		end
		if (rest_do) begin
			rested_q <= rem_q;
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= (cmd.emit != lobm_pkg::EM_NONE) || (cmd.fill && (n_q != '0));
		end
	end

	always_ff @(posedge clk) begin
		taker_ref    <= ref_q;
		result_kind  <= lobm_pkg::KIND_TRADE;
		last_of_run  <= 1'b0;
		maker_ref    <= pm_q;
		maker_trader <= pt_q;
		trade_price  <= pp_q;
		trade_qty    <= pq_q;
		taker_trader <= tr_q;
		taker_side   <= side_q;
		rested_qty   <= '0;
		unique case (cmd.emit)
			lobm_pkg::EM_PEND_LAST: begin
				last_of_run <= 1'b1;
				rested_qty  <= rested_q;
			end
			lobm_pkg::EM_DONE: begin
				result_kind  <= lobm_pkg::KIND_DONE;
				last_of_run  <= 1'b1;
				maker_ref    <= '0;
				maker_trader <= '0;
				trade_price  <= '0;
				trade_qty    <= '0;
				rested_qty   <= rested_q;
			end
			lobm_pkg::EM_REJECT: begin
				result_kind  <= lobm_pkg::KIND_REJECT;
				last_of_run  <= 1'b1;
				maker_ref    <= '0;
				maker_trader <= '0;
				trade_price  <= '0;
				trade_qty    <= '0;
				taker_trader <= type_q ? '0 : tr_q;
				taker_side   <= type_q ? 1'b0 : side_q;
			end
			lobm_pkg::EM_CANCEL: begin
				result_kind  <= lobm_pkg::KIND_DONE;
				last_of_run  <= 1'b1;
				maker_ref    <= '0;
				maker_trader <= '0;
				trade_price  <= '0;
				trade_qty    <= '0;
				taker_trader <= ftr_q;
				taker_side   <= (fidx_q >= IW'(SLOTS_PER_SIDE));
			end
			default: begin
			end
		endcase
	end

	assign stat.scan_done = (left_q == '0) && !v_s1;
	assign stat.is_cancel = type_q;
	assign stat.found     = fnd_q;
	assign stat.best_ok   = bok_q;
	assign stat.cont      = (rem_q != '0) && (n_q != NW'(SLOTS_PER_SIDE));
	assign stat.n_zero    = (n_q == '0);
	assign stat.n_full    = (n_q == NW'(SLOTS_PER_SIDE));
	assign stat.reject    = rej_q;

endmodule
